>>> hdl/alkd_pkg.sv
package alkd_pkg;

	// number of adc channels in the round robin; channel 0 carries the keypad
	localparam int unsigned CHANNELS = 4;
	// stored auxiliary channels (channels 1 to 3)
	localparam int unsigned AUX_DEPTH = 3;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned CH_W     = 2;
	localparam int unsigned BTN_W    = 3;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned IDX_W    = 2;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned REG_W    = 10;
	localparam int unsigned REGIDX_W = 3;

	localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
	localparam logic [SAMPLE_W-1:0] AUX_RESET = '1;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CH_W-1:0]     chan_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE   = 2'd0,
		KIND_READ_BTN = 2'd1,
		KIND_READ_AUX = 2'd2,
		KIND_UNUSED   = 2'd3
	} kind_t;

	typedef enum logic [BTN_W-1:0] {
		KEY_NONE  = 3'd0,
		KEY_RIGHT = 3'd1,
		KEY_UP    = 3'd2,
		KEY_DOWN  = 3'd3,
		KEY_LEFT  = 3'd4,
		KEY_ENTER = 3'd5
	} button_t;

	typedef enum logic [REGIDX_W-1:0] {
		REG_THRESHOLD   = 3'd0,
		REG_LIMIT_RIGHT = 3'd1,
		REG_LIMIT_UP    = 3'd2,
		REG_LIMIT_DOWN  = 3'd3,
		REG_LIMIT_LEFT  = 3'd4,
		REG_LIMIT_ENTER = 3'd5
	} reg_index_t;

	typedef struct packed {
		sample_t threshold;
		sample_t limit_right;
		sample_t limit_up;
		sample_t limit_down;
		sample_t limit_left;
		sample_t limit_enter;
	} cfg_t;

	typedef struct packed {
		kind_t               kind;
		sample_t             sample;
		logic [IDX_W-1:0]    read_index;
	} item_t;

	typedef struct packed {
		button_t button;
		sample_t aux_value;
		chan_t   next_channel;
	} result_t;

endpackage

>>> hdl/adc_ladder_keypad_decoder.sv
// an accepted word is held in the input register, then in the result register
// throughput: one word per cycle, held up only by back-pressure from the result side
// reset (arst_n, asynchronous, active low): channel 0, debounce count 0, no button latched,
// processed flag clear, stored channel samples 1023, band limits and threshold to defaults
module adc_ladder_keypad_decoder (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample[9:0], read_index[11:10], zero pad[15:12]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // button[2:0], aux_value[12:3], next_channel[14:13], pad
);
	import alkd_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;

	result_t result;
	button_t band;
	logic    advance;

	// configuration registers; user writes only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold   <= sample_t'(280);
			cfg_q.limit_right <= sample_t'(50);
			cfg_q.limit_up    <= sample_t'(195);
			cfg_q.limit_down  <= sample_t'(380);
			cfg_q.limit_left  <= sample_t'(555);
			cfg_q.limit_enter <= sample_t'(790);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD:   cfg_q.threshold   <= cfg_data;
				REG_LIMIT_RIGHT: cfg_q.limit_right <= cfg_data;
				REG_LIMIT_UP:    cfg_q.limit_up    <= cfg_data;
				REG_LIMIT_DOWN:  cfg_q.limit_down  <= cfg_data;
				REG_LIMIT_LEFT:  cfg_q.limit_left  <= cfg_data;
				REG_LIMIT_ENTER: cfg_q.limit_enter <= cfg_data;
				default: ;  // indexes beyond the register list are ignored
			endcase
		end
	end

	// the held word moves into the result register whenever that register is
	// empty or being drained; the decoder state updates on the same edge
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.kind       <= kind_t'(s_tuser);
			item_s1.sample     <= s_tdata[SAMPLE_W-1:0];
			item_s1.read_index <= s_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W];
		end
	end

	// band decode of the held sample
	alkd_classify u_classify (
		.sample (item_s1.sample),
		.cfg    (cfg_q),
		.band   (band)
	);

	// debounce, latch, channel round robin and stored samples
	alkd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.band      (band),
		.threshold (cfg_q.threshold),
		.result    (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {1'b0, result_s2.next_channel, result_s2.aux_value, result_s2.button};

endmodule

>>> hdl/alkd_classify.sv
module alkd_classify (
	input  alkd_pkg::sample_t sample,
	input  alkd_pkg::cfg_t    cfg,
	output alkd_pkg::button_t band
);
	import alkd_pkg::*;

	// first limit the sample sits below wins, even with limits out of order
	always_comb begin
		if (sample < cfg.limit_right) begin
			band = KEY_RIGHT;
		end else if (sample < cfg.limit_up) begin
			band = KEY_UP;
		end else if (sample < cfg.limit_down) begin
			band = KEY_DOWN;
		end else if (sample < cfg.limit_left) begin
			band = KEY_LEFT;
		end else if (sample < cfg.limit_enter) begin
			band = KEY_ENTER;
		end else begin
			band = KEY_NONE;
		end
	end

endmodule

>>> hdl/alkd_core.sv
module alkd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  alkd_pkg::item_t   item,
	input  alkd_pkg::button_t band,
	input  alkd_pkg::sample_t threshold,
	output alkd_pkg::result_t result
);
	import alkd_pkg::*;

	chan_t   chan_q;
	count_t  count_q;
	button_t latch_q;
	logic    processed_q;
	sample_t aux_q [AUX_DEPTH];

	chan_t   chan_d;
	count_t  count_d;
	count_t  count_inc;
	button_t latch_d;
	logic    processed_d;
	logic    aux_we;
	chan_t   aux_sel;
	sample_t aux_rd;
	logic    is_sample;

	assign is_sample = (item.kind == KIND_SAMPLE);
	assign count_inc = (count_q < COUNT_MAX) ? count_q + count_t'(1) : count_q;
	assign aux_sel   = chan_q - chan_t'(1);

	always_comb begin
		count_d     = count_q;
		latch_d     = latch_q;
		processed_d = processed_q;
		chan_d      = chan_q;
		aux_we      = 1'b0;
		case (item.kind)
			KIND_SAMPLE: begin
				if (chan_q == chan_t'(0)) begin
					if (band != KEY_NONE) begin
						if (count_inc > count_t'(threshold)) begin
							count_d     = '0;
							processed_d = 1'b0;
							latch_d     = band;
						end else begin
							count_d = count_inc;
						end
					end else begin
						count_d = '0;
						if (processed_q) begin
							latch_d = KEY_NONE;
						end
					end
				end else if (32'(chan_q) < CHANNELS && 32'(aux_sel) < AUX_DEPTH) begin
					aux_we = 1'b1;
				end
				if (32'(chan_q) + 32'd1 < CHANNELS) begin
					chan_d = chan_q + chan_t'(1);
				end else begin
					chan_d = '0;
				end
			end
			KIND_READ_BTN: begin
				if (latch_q != KEY_NONE) begin
					processed_d = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		case (item.read_index)
			2'd0:    aux_rd = aux_q[0];
			2'd1:    aux_rd = aux_q[1];
			2'd2:    aux_rd = aux_q[2];
			default: aux_rd = '0;
		endcase
	end

	assign result.button       = latch_d;
	assign result.aux_value    = (item.kind == KIND_READ_AUX) ? aux_rd : '0;
	assign result.next_channel = chan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			count_q     <= '0;
			latch_q     <= KEY_NONE;
			processed_q <= 1'b0;
		end else if (advance) begin
			chan_q      <= chan_d;
			count_q     <= count_d;
			latch_q     <= latch_d;
			processed_q <= processed_d;
		end
	end

	// stored channel samples start out at full scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AUX_DEPTH; i++) begin
				aux_q[i] <= AUX_RESET;
			end
		end else if (advance && is_sample && aux_we) begin
			aux_q[aux_sel[IDX_W-1:0]] <= item.sample;
		end
	end

endmodule

>>> hdl/alkd_checker.sv
module alkd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import alkd_pkg::*;

	// a stalled result word holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// with nothing waiting on the result side the input is never held off
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// latched button is always a defined code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
		else $error("undefined button code");

	// next channel stays inside the round robin
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[14:13]) < CHANNELS)
		else $error("next channel out of range");

endmodule

bind adc_ladder_keypad_decoder alkd_checker u_alkd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/sv/adc_ladder_keypad_decoder_tb.sv
module adc_ladder_keypad_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import alkd_pkg::*;

	// one row of the directed table; want is only used where fixed is set
	typedef struct {
		kind_t               kind;
		sample_t             sample;
		logic [IDX_W-1:0]    idx;
		bit                  fixed;
		result_t             want;
	} stim_row_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [9:0]  cfg_data   = '0;
	logic        s_tvalid   = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata    = '0;   // sample[9:0], read_index[11:10], zero pad[15:12]
	logic [1:0]  s_tuser    = '0;   // kind[1:0]
	logic        m_tvalid;
	logic        m_tready   = 1'b0;
	logic [15:0] m_tdata;           // button[2:0], aux_value[12:3], next_channel[14:13], pad

	adc_ladder_keypad_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// predicted keypad state, kept in step with every accepted input word
	cfg_t    cfg_now;
	chan_t   chan;
	count_t  press_count;
	button_t held_key;
	logic    taken;
	sample_t aux_store [AUX_DEPTH];

	// readouts still owed by the block, oldest first
	result_t pending_readouts [$];
	int      mismatches = 0;

	// idling percentages for the two sides
	int gap_pct   = 0;
	int stall_pct = 0;

	// key-hold model for channel 0 samples
	int      hold_left = 0;
	sample_t hold_val  = '0;

	// directed table: extremes, every kind, reads with nothing latched, index three
	stim_row_t directed_rows [24] = '{
		'{KIND_READ_BTN, 10'd0,    2'd0, 1'b1, '{KEY_NONE, 10'd0,    2'd0}},
		'{KIND_READ_AUX, 10'd0,    2'd0, 1'b1, '{KEY_NONE, 10'd1023, 2'd0}},
		'{KIND_READ_AUX, 10'd0,    2'd1, 1'b1, '{KEY_NONE, 10'd1023, 2'd0}},
		'{KIND_READ_AUX, 10'd0,    2'd2, 1'b1, '{KEY_NONE, 10'd1023, 2'd0}},
		'{KIND_READ_AUX, 10'd1023, 2'd3, 1'b1, '{KEY_NONE, 10'd0,    2'd0}},
		'{KIND_UNUSED,   10'd1023, 2'd3, 1'b1, '{KEY_NONE, 10'd0,    2'd0}},
		'{KIND_SAMPLE,   10'd0,    2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd1023, 2'd3, 1'b0, '0},
		'{KIND_SAMPLE,   10'd0,    2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd682,  2'd1, 1'b0, '0},
		'{KIND_READ_AUX, 10'd0,    2'd1, 1'b0, '0},
		'{KIND_READ_AUX, 10'd0,    2'd2, 1'b0, '0},
		'{KIND_SAMPLE,   10'd49,   2'd2, 1'b0, '0},
		'{KIND_SAMPLE,   10'd341,  2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd1023, 2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd0,    2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd50,   2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd789,  2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd790,  2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd1022, 2'd0, 1'b0, '0},
		'{KIND_SAMPLE,   10'd790,  2'd0, 1'b0, '0},
		'{KIND_READ_BTN, 10'd0,    2'd0, 1'b0, '0},
		'{KIND_UNUSED,   10'd0,    2'd0, 1'b0, '0},
		'{KIND_READ_AUX, 10'd0,    2'd0, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous cap on the whole run
	initial begin
		#3_000_000;
		$display("FAILURE");
		$finish;
	end

	// first band limit the sample sits below wins, so unordered limits still decode
	function automatic button_t band_of(input sample_t s);
		if (s < cfg_now.limit_right) return KEY_RIGHT;
		if (s < cfg_now.limit_up)    return KEY_UP;
		if (s < cfg_now.limit_down)  return KEY_DOWN;
		if (s < cfg_now.limit_left)  return KEY_LEFT;
		if (s < cfg_now.limit_enter) return KEY_ENTER;
		return KEY_NONE;
	endfunction

	// advances the predicted state by one word and returns the readout it causes
	function automatic result_t keypad_step(input kind_t k, input sample_t s,
			input logic [IDX_W-1:0] idx);
		result_t r;
		button_t b;
		r.aux_value = '0;
		case (k)
			KIND_SAMPLE: begin
				if (chan == '0) begin
					b = band_of(s);
					if (b != KEY_NONE) begin
						// shared counter, saturating; exceeding the threshold latches and rearms
						if (press_count != COUNT_MAX) press_count = press_count + 1'b1;
						if (press_count > count_t'(cfg_now.threshold)) begin
							press_count = '0;
							taken       = 1'b0;
							held_key    = b;
						end
					end else begin
						// key released: drop the latch only once it has been read
						press_count = '0;
						if (taken) held_key = KEY_NONE;
					end
				end else if (int'(chan) < CHANNELS && int'(chan) - 1 < AUX_DEPTH) begin
					aux_store[int'(chan) - 1] = s;
				end
				chan = (int'(chan) + 1 < CHANNELS) ? chan + 1'b1 : '0;
			end
			KIND_READ_BTN: begin
				// a read with nothing latched leaves the flag alone
				if (held_key != KEY_NONE) taken = 1'b1;
			end
			KIND_READ_AUX: begin
				if (idx < AUX_DEPTH) r.aux_value = aux_store[idx];
			end
			default: ;
		endcase
		r.button       = held_key;
		r.next_channel = chan;
		return r;
	endfunction

	// writes all six registers; only called with nothing in flight
	task automatic write_config(input cfg_t c);
		reg_index_t ri [6];
		sample_t    v  [6];
		ri = '{REG_THRESHOLD, REG_LIMIT_RIGHT, REG_LIMIT_UP,
			REG_LIMIT_DOWN, REG_LIMIT_LEFT, REG_LIMIT_ENTER};
		v  = '{c.threshold, c.limit_right, c.limit_up,
			c.limit_down, c.limit_left, c.limit_enter};
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= ri[i];
			cfg_data  <= v[i];
			@(negedge clk);
		end
		cfg_we  <= 1'b0;
		cfg_now = c;
	endtask

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input kind_t k, input sample_t s, input logic [IDX_W-1:0] idx,
			input bit fixed, input result_t want);
		result_t guess;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, idx, s};
		s_tuser  <= k;
		do @(posedge clk); while (!s_tready);
		// predictor runs on every word so the state stays right behind typed rows too
		guess = keypad_step(k, s, idx);
		pending_readouts.push_back(fixed ? want : guess);
		@(negedge clk);
	endtask

	// channel 0 samples mostly hold a key for a while, then let go
	function automatic sample_t keypad_sample();
		sample_t lim [5];
		int      top;
		lim = '{cfg_now.limit_right, cfg_now.limit_up, cfg_now.limit_down,
			cfg_now.limit_left, cfg_now.limit_enter};
		if (hold_left == 0) begin
			if ($urandom_range(99) < 30) begin
				case ($urandom_range(2))
					0:       hold_val = 10'd1023;
					1:       hold_val = cfg_now.limit_enter;
					default: hold_val = sample_t'($urandom_range(1023));
				endcase
				hold_left = $urandom_range(1, 3);
			end else begin
				case ($urandom_range(2))
					0:       hold_val = lim[$urandom_range(4)] - 1'b1;
					1:       hold_val = lim[$urandom_range(4)];
					default: hold_val = (cfg_now.limit_enter == '0) ? sample_t'($urandom_range(1023))
						: sample_t'($urandom_range(int'(cfg_now.limit_enter) - 1));
				endcase
				top = (int'(cfg_now.threshold) > 20) ? 60 : 3 * int'(cfg_now.threshold) + 6;
				hold_left = $urandom_range(1, top);
			end
		end
		hold_left--;
		return hold_val;
	endfunction

	task automatic run_phase(input int n, input int gap, input int stall);
		kind_t            k;
		sample_t          s;
		logic [IDX_W-1:0] idx;
		int               r;
		gap_pct   = gap;
		stall_pct = stall;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 14)      k = KIND_READ_BTN;
			else if (r < 24) k = KIND_READ_AUX;
			else if (r < 27) k = KIND_UNUSED;
			else             k = KIND_SAMPLE;
			s   = sample_t'($urandom_range(1023));
			idx = IDX_W'($urandom_range(3));
			// a few channel 0 samples are plain noise, breaking up the holds
			if (k == KIND_SAMPLE && chan == '0 && $urandom_range(99) >= 5) s = keypad_sample();
			send_word(k, s, idx, 1'b0, '0);
		end
		s_tvalid <= 1'b0;
	endtask

	// wait for the block to drain, then a little extra for the input and result registers
	task automatic drain();
		while (pending_readouts.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// receiver back-pressure
	always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	// result side: every readout word against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_readouts.size() == 0) begin
				$display("%0t: readout word with none pending: button %0d aux %0d ch %0d",
					$time, m_tdata[2:0], m_tdata[12:3], m_tdata[14:13]);
				mismatches++;
			end else begin
				want = pending_readouts.pop_front();
				if (m_tdata[2:0] !== want.button || m_tdata[12:3] !== want.aux_value
						|| m_tdata[14:13] !== want.next_channel) begin
					$display("%0t: expected button %0d aux %0d ch %0d", $time,
						want.button, want.aux_value, want.next_channel,
						", got button %0d aux %0d ch %0d",
						m_tdata[2:0], m_tdata[12:3], m_tdata[14:13]);
					mismatches++;
				end
			end
		end
	end

	initial begin
		// reset values of the predicted state
		cfg_now     = '{threshold: 10'd280, limit_right: 10'd50, limit_up: 10'd195,
			limit_down: 10'd380, limit_left: 10'd555, limit_enter: 10'd790};
		chan        = '0;
		press_count = '0;
		held_key    = KEY_NONE;
		taken       = 1'b0;
		foreach (aux_store[i]) aux_store[i] = AUX_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table at reset settings, no idling
		foreach (directed_rows[i])
			send_word(directed_rows[i].kind, directed_rows[i].sample, directed_rows[i].idx,
				directed_rows[i].fixed, directed_rows[i].want);
		s_tvalid <= 1'b0;

		// random phases; each setting written with the block drained
		run_phase(150, 0, 0);
		drain();
		write_config('{10'd2, 10'd50, 10'd195, 10'd380, 10'd555, 10'd790});
		run_phase(200, 70, 0);
		drain();
		// limits out of order: first band hit wins
		write_config('{10'd0, 10'd600, 10'd100, 10'd700, 10'd300, 10'd1023});
		run_phase(200, 0, 70);
		drain();
		// top extremes: everything below 1023 is right, never latches in this run
		write_config('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
		run_phase(150, 31, 31);
		drain();
		// bottom extremes: no band at all
		write_config('{10'd1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
		run_phase(100, 0, 0);
		drain();
		write_config('{10'd5, 10'd10, 10'd20, 10'd30, 10'd40, 10'd50});
		run_phase(200, 31, 31);
		drain();
		write_config('{10'd3, 10'd200, 10'd400, 10'd600, 10'd800, 10'd1000});
		run_phase(200, 70, 0);

		drain();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
